@@ rtl/core/square_matrix_multiply_transpose_unit_assert.svh @@
// Assertion macros shared by the matrix multiply unit.
`ifndef SQUARE_MATRIX_MULTIPLY_TRANSPOSE_UNIT_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_TRANSPOSE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SMM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked during reset as well.
`define SMM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/core/smmt_pkg.sv @@
// ----------------------------------------------------------------------------
// smmt_pkg
// Types and constants of the matrix multiply unit.
// ----------------------------------------------------------------------------
package smmt_pkg;
   localparam int MAX_DIM = 8;
   localparam int IDX_W = 3;
   localparam int ADDR_W = 6;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W = 72;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_B = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [IDX_W-1:0] last_idx;
      logic             trans_a;
      logic             trans_b;
   } job_type;
endpackage

@@ rtl/core/square_matrix_multiply_transpose_unit.sv @@
// ----------------------------------------------------------------------------
// square_matrix_multiply_transpose_unit
// Q16.16 square matrix multiply C = op(A) * op(B) with optional transposes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/stall    | operation, row, col, value
//  rsp_     | out       | rsp_valid/stall    | out_row, out_col, out_value, saturated, last
//  csr_     | in        | csr_write          | csr_index, csr_data
//
// A load request writes one store word. A compute request gives n*n results;
// each result is formed by the single multiply-accumulate loop over k and the
// two-stage read and multiply pipeline, then delivered. A job is picked up
// from the queue while the sequencer is idle.
// Reset is synchronous, clears the queue and the sequencer and sets size 8, no transposes;
// the stores hold undefined data until written.
// The front stalls when both queue slots hold compute jobs, and it holds off
// loads while any compute is queued or running.
module square_matrix_multiply_transpose_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_operation,
   input  logic [smmt_pkg::IDX_W-1:0] req_row,
   input  logic [smmt_pkg::IDX_W-1:0] req_col,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [smmt_pkg::IDX_W-1:0] rsp_out_row,
   output logic [smmt_pkg::IDX_W-1:0] rsp_out_col,
   output logic signed [31:0]         rsp_out_value,
   output logic                       rsp_saturated,
   output logic                       rsp_last,
   input  logic                       csr_write,
   input  logic [smmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [3:0]                 csr_data
);
   import smmt_pkg::*;

   logic              wr_a, wr_b, job_valid, job_take, back_busy;
   logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
   logic [31:0]       wr_data, rd_data_a, rd_data_b;
   job_type           job;

   // Loads wait while the back is busy or a job is queued, so every compute
   // sees exactly the operands written before it in the request stream.
   smmt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_row, .req_col,
      .req_value, .csr_write, .csr_index, .csr_data, .wr_a, .wr_b, .wr_addr,
      .wr_data, .job_valid, .job, .job_take, .back_busy
   );

   smmt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_a (
      .clock, .wr_en(wr_a), .wr_addr, .wr_data, .rd_addr(rd_addr_a), .rd_data(rd_data_a)
   );

   smmt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store_b (
      .clock, .wr_en(wr_b), .wr_addr, .wr_data, .rd_addr(rd_addr_b), .rd_data(rd_data_b)
   );

   smmt_back u_back (
      .clock, .reset, .job_valid, .job, .job_take, .back_busy, .rd_addr_a, .rd_addr_b,
      .rd_data_a, .rd_data_b, .rsp_valid, .rsp_stall, .rsp_out_row, .rsp_out_col,
      .rsp_out_value, .rsp_saturated, .rsp_last
   );
endmodule

@@ rtl/core/smmt_ram.sv @@
// ----------------------------------------------------------------------------
// smmt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module smmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/smmt_front.sv @@
// ----------------------------------------------------------------------------
// smmt_front
// Accepts requests, writes loads to the stores and queues compute jobs.
// ----------------------------------------------------------------------------
module smmt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [smmt_pkg::IDX_W-1:0] req_row,
   input  logic [smmt_pkg::IDX_W-1:0] req_col,
   input  logic signed [31:0]        req_value,
   input  logic                      csr_write,
   input  logic [smmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [3:0]                csr_data,
   output logic                      wr_a,
   output logic                      wr_b,
   output logic [smmt_pkg::ADDR_W-1:0] wr_addr,
   output logic [31:0]               wr_data,
   output logic                      job_valid,
   output smmt_pkg::job_type         job,
   input  logic                      job_take,
   input  logic                      back_busy
);
   import smmt_pkg::*;
   `include "square_matrix_multiply_transpose_unit_assert.svh"

   logic [3:0] size_ff;
   logic       ta_ff, tb_ff;
   job_type    q_ff [QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wp_ff;
   logic       accept, push, load_op;
   job_type    new_job;

   // A load waits until every earlier compute has finished reading the stores.
   assign load_op = (req_operation == OP_LOAD_A) || (req_operation == OP_LOAD_B);
   assign req_stall = (cnt_ff == 2'(QUEUE_DEPTH)) || (load_op && (job_valid || back_busy));
   assign accept = req_valid && !req_stall;
   assign push = accept && (req_operation == OP_COMPUTE);
   assign wr_a = accept && (req_operation == OP_LOAD_A);
   assign wr_b = accept && (req_operation == OP_LOAD_B);
   assign wr_addr = {req_row, req_col};
   assign wr_data = req_value;

   always_comb begin
      new_job.trans_a = ta_ff;
      new_job.trans_b = tb_ff;
      if (size_ff == 4'd0) begin
         new_job.last_idx = '0;
      end else if (size_ff > 4'(MAX_DIM)) begin
         new_job.last_idx = IDX_W'(MAX_DIM - 1);
      end else begin
         new_job.last_idx = IDX_W'(size_ff - 4'd1);
      end
   end

   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rd_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(job_take && job_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 4'd8;
         ta_ff <= 1'b0;
         tb_ff <= 1'b0;
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wp_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MATRIX_SIZE: size_ff <= csr_data;
               CSR_TRANSPOSE_A: ta_ff <= csr_data[0];
               CSR_TRANSPOSE_B: tb_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (push) begin
            q_ff[wp_ff] <= new_job;
            wp_ff <= !wp_ff;
         end
         if (job_take && job_valid) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   `SMM_ASSERT(a_no_overflow, clock, reset, push |-> cnt_ff < 2'(QUEUE_DEPTH), "queue overflow")
   `SMM_ASSERT(a_count_range, clock, reset, cnt_ff <= 2'(QUEUE_DEPTH), "queue count out of range")
   `SMM_ASSERT(a_excl_write, clock, reset, !(wr_a && wr_b) && !((wr_a || wr_b) && push), "bad classify")
   `SMM_ASSERT(a_load_order, clock, reset, (wr_a || wr_b) |-> !job_valid && !back_busy, "load passed a compute")
endmodule

@@ rtl/core/smmt_back.sv @@
// ----------------------------------------------------------------------------
// smmt_back
// Runs a compute job: one multiply-accumulate per cycle over the stores in run state.
// ----------------------------------------------------------------------------
module smmt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  smmt_pkg::job_type         job,
   output logic                      job_take,
   output logic                      back_busy,
   output logic [smmt_pkg::ADDR_W-1:0] rd_addr_a,
   output logic [smmt_pkg::ADDR_W-1:0] rd_addr_b,
   input  logic [31:0]               rd_data_a,
   input  logic [31:0]               rd_data_b,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [smmt_pkg::IDX_W-1:0] rsp_out_row,
   output logic [smmt_pkg::IDX_W-1:0] rsp_out_col,
   output logic signed [31:0]        rsp_out_value,
   output logic                      rsp_saturated,
   output logic                      rsp_last
);
   import smmt_pkg::*;
   `include "square_matrix_multiply_transpose_unit_assert.svh"

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_type;
   state_type state_ff;

   job_type          job_ff;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff;
   // Pipeline flags: v1/v2 valid for read issued and product formed, e1/e2 mark the last k.
   logic             v1_ff, v2_ff, e1_ff, e2_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic             rv_ff;
   logic [IDX_W-1:0] orow_ff, ocol_ff;
   logic signed [31:0] oval_ff;
   logic             osat_ff, olast_ff;
   logic [IDX_W-1:0] ia, ka, kb, jb;
   logic signed [ACC_W-1:0] acc_sum, shifted;
   logic             issue, last_k;

   assign ia = i_ff;
   assign ka = k_ff;
   assign kb = k_ff;
   assign jb = j_ff;
   assign rd_addr_a = job_ff.trans_a ? {ka, ia} : {ia, ka};
   assign rd_addr_b = job_ff.trans_b ? {jb, kb} : {kb, jb};
   assign issue = (state_ff == S_RUN);
   assign last_k = (k_ff == job_ff.last_idx);
   assign job_take = (state_ff == S_IDLE);
   assign back_busy = (state_ff != S_IDLE);
   assign acc_sum = acc_ff + ACC_W'(prod_ff);
   assign shifted = acc_sum >>> 16;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rv_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff <= issue;
         e1_ff <= issue && last_k;
         v2_ff <= v1_ff;
         e2_ff <= e1_ff;
         if (v1_ff) prod_ff <= $signed(rd_data_a) * $signed(rd_data_b);
         if (v2_ff) acc_ff <= e2_ff ? '0 : acc_sum;
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  i_ff <= '0;
                  j_ff <= '0;
                  k_ff <= '0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (last_k) begin
                  k_ff <= '0;
                  state_ff <= S_DRAIN;
               end else begin
                  k_ff <= k_ff + IDX_W'(1);
               end
            end
            S_DRAIN: begin
               if (v2_ff && e2_ff) begin
                  if (shifted > 72'sd2147483647) begin
                     oval_ff <= 32'sh7FFFFFFF;
                     osat_ff <= 1'b1;
                  end else if (shifted < -72'sd2147483648) begin
                     oval_ff <= 32'sh80000000;
                     osat_ff <= 1'b1;
                  end else begin
                     oval_ff <= shifted[31:0];
                     osat_ff <= 1'b0;
                  end
                  orow_ff <= i_ff;
                  ocol_ff <= j_ff;
                  olast_ff <= (i_ff == job_ff.last_idx) && (j_ff == job_ff.last_idx);
                  rv_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  if (olast_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     if (j_ff == job_ff.last_idx) begin
                        j_ff <= '0;
                        i_ff <= i_ff + IDX_W'(1);
                     end else begin
                        j_ff <= j_ff + IDX_W'(1);
                     end
                     state_ff <= S_RUN;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_row = orow_ff;
   assign rsp_out_col = ocol_ff;
   assign rsp_out_value = oval_ff;
   assign rsp_saturated = osat_ff;
   assign rsp_last = olast_ff;

   `SMM_ASSERT(a_out_state, clock, reset, rsp_valid |-> state_ff == S_OUT, "result outside output state")
   `SMM_ASSERT(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_out_value), "stalled result changed")
   `SMM_ASSERT(a_take_idle, clock, reset, job_take |-> !rsp_valid, "job taken while result pending")
endmodule
